// ===== hw/rtl/kls_pkg.sv =====
// ============================================================================
// kls_pkg: shared types and constants for the live slot select tree
// Payload structs, command codes, sequencer states and the status bundle.
// ============================================================================
package kls_pkg;

   localparam int POS_W = 10;  // slot position, rank and reported count
   localparam int CNT_W = 11;  // stored node count
   localparam int CMD_W = 2;

   localparam logic [POS_W-1:0] NUM_SLOTS_RESET = 10'd1023;

   typedef enum logic [CMD_W-1:0] {
      CMD_SELECT  = 2'd0,
      CMD_CLEAR   = 2'd1,
      CMD_RESTORE = 2'd2
   } kls_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [POS_W-1:0] rank;
      logic [POS_W-1:0] range_low;
      logic [POS_W-1:0] range_high;
   } kls_req_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             found;
      logic [POS_W-1:0] live_count;
   } kls_rsp_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_SELECT,
      ST_MARK,
      ST_FIX_KIDS,
      ST_FIX_SELF,
      ST_FIX_WRITE,
      ST_RESPOND
   } kls_state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } kls_alu_op_type;

   typedef struct packed {
      logic             idle;
      logic             done;
      logic [POS_W-1:0] position;
      logic             found;
      logic [POS_W-1:0] live_count;
   } kls_status_type;

endpackage

// ===== hw/rtl/kth_live_slot_select_tree.sv =====
// ============================================================================
// kth_live_slot_select_tree: rank select over live slots
// Count tree over LEAVES slots; select, range clear and restore commands.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  req     | in        | req_valid/req_ready  | kls_req_type (command, ...)
//  rsp     | out       | rsp_valid/rsp_ready  | kls_rsp_type (position, ...)
//  csr     | in        | csr_wr_en            | csr_wr_data = num_slots
//
// Select reads one child per level of the count tree; clear marks its cover
// nodes, then repairs two boundary paths node by node through FIX_KIDS,
// FIX_SELF and FIX_WRITE (once the paths meet, one path); restore rewrites
// every node. All of them go through the single count memory (one write, two reads).
// After reset a sweep zeroes the tree; req_ready stays low meanwhile, csr
// writes are taken.
// A finished result sits in the rsp register; req_ready returns as soon as
// that register is loaded, so a stalled consumer only stalls the next result.
//
module kth_live_slot_select_tree import kls_pkg::*; #(
   parameter int LEAVES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kls_req_type      req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kls_rsp_type      rsp_data,
   input  logic             csr_wr_en,
   input  logic [POS_W-1:0] csr_wr_data
);

   logic [POS_W-1:0] num_slots_ff, num_slots_in;
   logic             rsp_valid_ff, rsp_valid_in;
   kls_rsp_type      rsp_data_ff, rsp_data_in;

   kls_status_type   status;
   logic             req_xfer;
   logic             out_free;
   logic             rsp_load;

   assign req_ready = status.idle;
   assign req_xfer  = req_valid && req_ready;

   // the rsp register can take a result when empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = status.done && out_free;

   kls_ctrl #(
      .LEAVES(LEAVES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (req_xfer),
      .req      (req_data),
      .num_slots(num_slots_ff),
      .out_free (out_free),
      .status   (status)
   );

   always_comb begin
      num_slots_in = csr_wr_en ? csr_wr_data : num_slots_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.position   = status.position;
         rsp_data_in.found      = status.found;
         rsp_data_in.live_count = status.live_count;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_slots_ff <= NUM_SLOTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_slots_ff <= num_slots_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/kls_count_mem.sv =====
// ============================================================================
// kls_count_mem: node count storage
// One write port, two read ports, read data registered.
// ============================================================================
module kls_count_mem #(
   parameter int ADDR_W = 11,
   parameter int DATA_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr0,
   input  logic [ADDR_W-1:0] rd_addr1,
   output logic [DATA_W-1:0] rd_data0,
   output logic [DATA_W-1:0] rd_data1
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data0_ff;
   logic [DATA_W-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data0_ff <= mem[rd_addr0];
      rd_data1_ff <= mem[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

// ===== hw/rtl/kls_node_alu.sv =====
// ============================================================================
// kls_node_alu: shared count adder/subtractor
// Sums two child counts, or subtracts a left count from the remaining rank; le flags a <= b.
// ============================================================================
module kls_node_alu import kls_pkg::*; (
   input  kls_alu_op_type   op,
   input  logic [CNT_W-1:0] a,
   input  logic [CNT_W-1:0] b,
   output logic [CNT_W-1:0] y,
   output logic             le
);

   always_comb begin
      unique case (op)
         ALU_ADD: y = a + b;
         ALU_SUB: y = a - b;
         default: y = a + b;
      endcase
   end

   assign le = (a <= b);

endmodule

// ===== hw/rtl/kls_ctrl.sv =====
// ============================================================================
// kls_ctrl: command sequencer
// Walks the count tree for select, marks and repairs it for clear, and
// rewrites every node for restore and after reset.
// ============================================================================
module kls_ctrl import kls_pkg::*; #(
   parameter int LEAVES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  kls_req_type      req,
   input  logic [POS_W-1:0] num_slots,
   input  logic             out_free,
   output kls_status_type   status
);

   localparam int IDX_W  = $clog2(LEAVES);
   localparam int ADDR_W = IDX_W + 1;
   localparam int R_W    = ADDR_W + 1;
   localparam int LVL_W  = $clog2(IDX_W + 1);
   localparam int WIDE_W = ((R_W > POS_W) ? R_W : POS_W) + 1;

   localparam logic [WIDE_W-1:0] LAST_POS  = WIDE_W'(LEAVES - 1);
   localparam logic [R_W-1:0]    LEAF_BASE = R_W'(LEAVES);
   localparam logic [ADDR_W-1:0] ROOT      = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] FULL_SPAN = ADDR_W'(LEAVES);

   kls_state_type state_ff, state_in;

   logic [ADDR_W-1:0] t_ff, t_in;
   logic [POS_W-1:0]  x_ff, x_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [R_W-1:0]    l_ff, l_in;
   logic [R_W-1:0]    r_ff, r_in;
   logic [ADDR_W-1:0] pa_ff, pa_in;
   logic [ADDR_W-1:0] pb_ff, pb_in;
   logic              side_ff, side_in;
   logic [CNT_W-1:0]  sum_ff, sum_in;
   logic [ADDR_W-1:0] sw_i_ff, sw_i_in;
   logic [ADDR_W-1:0] sw_start_ff, sw_start_in;
   logic [ADDR_W-1:0] sw_span_ff, sw_span_in;
   logic [POS_W-1:0]  n_ff, n_in;
   logic              restore_ff, restore_in;
   logic [CNT_W-1:0]  root_ff, root_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              found_ff, found_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  wr_data;
   logic [ADDR_W-1:0] rd_addr0;
   logic [ADDR_W-1:0] rd_addr1;
   logic [CNT_W-1:0]  rd_data0;
   logic [CNT_W-1:0]  rd_data1;

   kls_alu_op_type    alu_op;
   logic [CNT_W-1:0]  alu_a;
   logic [CNT_W-1:0]  alu_b;
   logic [CNT_W-1:0]  alu_y;
   logic              alu_le;

   // request decode
   logic [WIDE_W-1:0] lo_w, hi_w, hi_c, ns_w;
   logic              clear_empty;
   logic [R_W-1:0]    leaf_lo, leaf_hi;
   logic [POS_W-1:0]  n_clamp;
   logic              rank_ok;

   // walk and repair helpers
   logic [ADDR_W-1:0] t_step;
   logic [ADDR_W-1:0] cur;
   logic              l_lt_r;
   logic [R_W-1:0]    r_dec;

   // sweep helpers
   logic [WIDE_W-1:0] nplus, st_w, span_w, rem_w, capped;
   logic [CNT_W-1:0]  sw_count;
   logic [ADDR_W-1:0] sw_next_start;
   logic              sw_level_end;
   logic              sw_last;

   kls_count_mem #(
      .ADDR_W(ADDR_W),
      .DATA_W(CNT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr0(rd_addr0),
      .rd_addr1(rd_addr1),
      .rd_data0(rd_data0),
      .rd_data1(rd_data1)
   );

   kls_node_alu u_alu (
      .op(alu_op),
      .a (alu_a),
      .b (alu_b),
      .y (alu_y),
      .le(alu_le)
   );

   assign lo_w        = WIDE_W'(req.range_low);
   assign hi_w        = WIDE_W'(req.range_high);
   assign hi_c        = (hi_w > LAST_POS) ? LAST_POS : hi_w;
   assign clear_empty = (lo_w > hi_c);
   assign leaf_lo     = LEAF_BASE + R_W'(lo_w);
   assign leaf_hi     = LEAF_BASE + R_W'(hi_c);
   assign ns_w        = WIDE_W'(num_slots);
   assign n_clamp     = POS_W'((ns_w > LAST_POS) ? LAST_POS : ns_w);
   assign rank_ok     = (req.rank != '0) && alu_le;

   assign t_step = {t_ff[ADDR_W-2:0], ~alu_le};
   assign cur    = side_ff ? pb_ff : pa_ff;
   assign l_lt_r = (l_ff < r_ff);
   assign r_dec  = r_ff - R_W'(1);

   // live slots under a node spanning [start, start+span) when 1..n are live
   assign nplus    = WIDE_W'(n_ff) + WIDE_W'(1);
   assign st_w     = WIDE_W'(sw_start_ff);
   assign span_w   = WIDE_W'(sw_span_ff);
   assign rem_w    = nplus - st_w;
   assign capped   = (rem_w < span_w) ? rem_w : span_w;
   assign sw_count = (st_w >= nplus) ? '0
                   : CNT_W'(capped - WIDE_W'(sw_start_ff == '0));
   assign sw_next_start = sw_start_ff + sw_span_ff;
   assign sw_level_end  = (sw_next_start == FULL_SPAN);
   assign sw_last       = &sw_i_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (sw_last) begin
               state_in = restore_ff ? ST_RESPOND : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req.command)
                  CMD_SELECT:  state_in = rank_ok ? ST_SELECT : ST_RESPOND;
                  CMD_CLEAR:   state_in = clear_empty ? ST_RESPOND : ST_MARK;
                  CMD_RESTORE: state_in = ST_SWEEP;
                  default:     state_in = ST_RESPOND;
               endcase
            end
         end
         ST_SELECT: begin
            if (lvl_ff == LVL_W'(1)) begin
               state_in = ST_RESPOND;
            end
         end
         ST_MARK: begin
            if (!l_lt_r) begin
               state_in = ST_FIX_KIDS;
            end
         end
         ST_FIX_KIDS:  state_in = ST_FIX_SELF;
         ST_FIX_SELF:  state_in = ST_FIX_WRITE;
         ST_FIX_WRITE: state_in = (cur == ROOT) ? ST_RESPOND : ST_FIX_KIDS;
         ST_RESPOND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      t_in        = t_ff;
      x_in        = x_ff;
      lvl_in      = lvl_ff;
      l_in        = l_ff;
      r_in        = r_ff;
      pa_in       = pa_ff;
      pb_in       = pb_ff;
      side_in     = side_ff;
      sum_in      = sum_ff;
      sw_i_in     = sw_i_ff;
      sw_start_in = sw_start_ff;
      sw_span_in  = sw_span_ff;
      n_in        = n_ff;
      restore_in  = restore_ff;
      pos_in      = pos_ff;
      found_in    = found_ff;
      wr_en       = 1'b0;
      wr_addr     = cur;
      wr_data     = '0;
      rd_addr0    = ADDR_W'(2);  // left child of the root, ready for select
      rd_addr1    = ADDR_W'(3);
      alu_op      = ALU_ADD;
      alu_a       = rd_data0;
      alu_b       = rd_data1;

      unique case (state_ff)
         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = sw_i_ff;
            wr_data = sw_count;
            sw_i_in = sw_i_ff + ADDR_W'(1);
            if (sw_level_end) begin
               sw_start_in = '0;
               sw_span_in  = sw_span_ff >> 1;
            end else begin
               sw_start_in = sw_next_start;
            end
         end
         ST_IDLE: begin
            alu_op = ALU_SUB;
            alu_a  = CNT_W'(req.rank);
            alu_b  = root_ff;
            if (start) begin
               pos_in   = '0;
               found_in = 1'b0;
               case (req.command)
                  CMD_SELECT: begin
                     t_in   = ROOT;
                     x_in   = req.rank;
                     lvl_in = LVL_W'(IDX_W);
                  end
                  CMD_CLEAR: begin
                     l_in    = leaf_lo;
                     r_in    = leaf_hi + R_W'(1);
                     pa_in   = ADDR_W'(leaf_lo >> 1);
                     pb_in   = ADDR_W'(leaf_hi >> 1);
                     side_in = 1'b0;
                  end
                  CMD_RESTORE: begin
                     n_in        = n_clamp;
                     restore_in  = 1'b1;
                     sw_i_in     = ROOT;
                     sw_start_in = '0;
                     sw_span_in  = FULL_SPAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SELECT: begin
            // rd_data0 holds the left child of t; le means descend left
            alu_op   = ALU_SUB;
            alu_a    = CNT_W'(x_ff);
            alu_b    = rd_data0;
            t_in     = t_step;
            x_in     = alu_le ? x_ff : POS_W'(alu_y);
            lvl_in   = lvl_ff - LVL_W'(1);
            rd_addr0 = {t_step[ADDR_W-2:0], 1'b0};
            if (lvl_ff == LVL_W'(1)) begin
               pos_in   = POS_W'(t_step[IDX_W-1:0]);
               found_in = 1'b1;
            end
         end
         ST_MARK: begin
            // bottom-up cover of [l, r): each covering node goes to zero
            if (l_lt_r) begin
               if (l_ff[0]) begin
                  wr_en   = 1'b1;
                  wr_addr = ADDR_W'(l_ff);
                  l_in    = l_ff + R_W'(1);
               end else if (r_ff[0]) begin
                  wr_en   = 1'b1;
                  wr_addr = ADDR_W'(r_dec);
                  r_in    = r_dec;
               end else begin
                  l_in = l_ff >> 1;
                  r_in = r_ff >> 1;
               end
            end
         end
         ST_FIX_KIDS: begin
            rd_addr0 = {cur[ADDR_W-2:0], 1'b0};
            rd_addr1 = {cur[ADDR_W-2:0], 1'b1};
         end
         ST_FIX_SELF: begin
            rd_addr0 = cur;
            sum_in   = alu_y;
         end
         ST_FIX_WRITE: begin
            // a node already at zero covers a dead subtree whose children
            // may be stale; it stays zero
            wr_en   = 1'b1;
            wr_addr = cur;
            wr_data = (rd_data0 == '0) ? '0 : sum_ff;
            if (!side_ff && (pa_ff != pb_ff)) begin
               side_in = 1'b1;
            end else begin
               side_in = 1'b0;
               pa_in   = pa_ff >> 1;
               pb_in   = pb_ff >> 1;
            end
         end
         ST_RESPOND: begin
         end
         default: begin
         end
      endcase
   end

   // root count mirrored in a register
   always_comb begin
      root_in = root_ff;
      if (wr_en && (wr_addr == ROOT)) begin
         root_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_SWEEP;
         sw_i_ff     <= ROOT;
         sw_start_ff <= '0;
         sw_span_ff  <= FULL_SPAN;
         n_ff        <= '0;
         restore_ff  <= 1'b0;
         root_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         sw_i_ff     <= sw_i_in;
         sw_start_ff <= sw_start_in;
         sw_span_ff  <= sw_span_in;
         n_ff        <= n_in;
         restore_ff  <= restore_in;
         root_ff     <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      x_ff     <= x_in;
      lvl_ff   <= lvl_in;
      l_ff     <= l_in;
      r_ff     <= r_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      side_ff  <= side_in;
      sum_ff   <= sum_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
   end

   assign status.idle       = (state_ff == ST_IDLE);
   assign status.done       = (state_ff == ST_RESPOND);
   assign status.position   = pos_ff;
   assign status.found      = found_ff;
   assign status.live_count = POS_W'(root_ff);

endmodule

// ===== hw/rtl/kls_port_checker.sv =====
// ============================================================================
// kls_port_checker: port-level checks for the live slot select tree
// Watches the req and rsp channels; attached to the top level by bind.
// ============================================================================
module kls_port_checker import kls_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input kls_rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped or changed while stalled");

   // no command is taken while the block works on the previous one; req_ready falls once a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken on consecutive cycles");

   // the tree clearing pass follows reset
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block ready right after reset");

   // slot zero is never live; a miss reports position zero
   a_position_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.found ? (rsp_data.position != '0)
                                    : (rsp_data.position == '0)))
      else $error("position inconsistent with found");

endmodule

bind kth_live_slot_select_tree kls_port_checker u_port_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
